>>> sv/assert_macros.svh
// Assertion helpers used by the queue design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDEQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BDEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> sv/bdeq_pkg.sv
package bdeq_pkg;

    localparam int DEPTH   = 16;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int WORD_W  = 32;
    localparam int FILL_W  = 5;
    localparam int CMD_W   = 3;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [CNT_W-1:0]         t_count;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_POP_FRONT  = 3'd1,
        CMD_PEEK_FRONT = 3'd2,
        CMD_PUSH_BACK  = 3'd3,
        CMD_POP_BACK   = 3'd4,
        CMD_PEEK_BACK  = 3'd5
    } t_cmd;

    // (base + offset) mod DEPTH, with base < DEPTH and offset <= DEPTH.
    function automatic t_addr ring_pos(input t_addr base, input t_count offset);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(offset);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

>>> sv/bdeq_ram.sv
module bdeq_ram #(
    parameter int DEPTH_P = 16,
    parameter int WIDTH_P = 32,
    parameter int ADDR_WP = (DEPTH_P > 1) ? $clog2(DEPTH_P) : 1
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [ADDR_WP-1:0] i_waddr,
    input  logic [WIDTH_P-1:0] i_wdata,
    input  logic               i_re,
    input  logic [ADDR_WP-1:0] i_raddr,
    output logic [WIDTH_P-1:0] o_rdata
);

    logic [WIDTH_P-1:0] mem [DEPTH_P];
    logic [WIDTH_P-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/bounded_double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit words in a ring buffer of DEPTH
// entries. Every accepted item (start high while busy is low) gives exactly one
// result, presented on the o_ports for one cycle with o_valid high in the
// cycle right after acceptance; the receiver must take it then. A new item may
// be accepted in every cycle, so the sustained rate is one item per clock, and
// the result is registered, as the read port of the storage memory is
// registered. busy is high only while reset is applied. A push to a full
// queue and a pop or peek on an empty one report o_ok low with zero data and
// leave the queue unchanged; unused command codes behave the same way.
`include "assert_macros.svh"

module bounded_double_ended_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [bdeq_pkg::CMD_W-1:0]  i_command,
    input  logic signed [bdeq_pkg::WORD_W-1:0] i_value,
    output logic                    o_valid,
    output logic                    o_ok,
    output logic signed [bdeq_pkg::WORD_W-1:0] o_data_out,
    output logic [bdeq_pkg::FILL_W-1:0] o_fill_count
);
    import bdeq_pkg::*;

    t_addr  r_head, n_head;
    t_count r_count, n_count;
    logic   r_valid;
    logic   r_ok;
    logic   r_rd;

    logic   accept;
    logic   full, empty;
    logic   ok;
    logic   we, re;
    t_addr  waddr, raddr;
    t_word  rdata;

    assign busy   = !i_rst_n;
    assign accept = start && !busy;
    assign full   = (r_count >= CNT_W'(DEPTH));
    assign empty  = (r_count == '0);

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        ok      = 1'b0;
        we      = 1'b0;
        re      = 1'b0;
        waddr   = r_head;
        raddr   = r_head;
        case (t_cmd'(i_command))
            CMD_PUSH_FRONT: begin
                if (!full) begin
                    n_head  = (r_head == '0) ? ADDR_W'(DEPTH - 1) : r_head - 1'b1;
                    waddr   = n_head;
                    we      = 1'b1;
                    n_count = r_count + 1'b1;
                    ok      = 1'b1;
                end
            end
            CMD_POP_FRONT, CMD_PEEK_FRONT: begin
                if (!empty) begin
                    raddr = r_head;
                    re    = 1'b1;
                    ok    = 1'b1;
                    if (t_cmd'(i_command) == CMD_POP_FRONT) begin
                        n_head  = ring_pos(r_head, CNT_W'(1));
                        n_count = r_count - 1'b1;
                    end
                end
            end
            CMD_PUSH_BACK: begin
                if (!full) begin
                    waddr   = ring_pos(r_head, r_count);
                    we      = 1'b1;
                    n_count = r_count + 1'b1;
                    ok      = 1'b1;
                end
            end
            CMD_POP_BACK, CMD_PEEK_BACK: begin
                if (!empty) begin
                    raddr = ring_pos(r_head, r_count - 1'b1);
                    re    = 1'b1;
                    ok    = 1'b1;
                    if (t_cmd'(i_command) == CMD_POP_BACK) begin
                        n_count = r_count - 1'b1;
                    end
                end
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    // A write and a later read of the same entry never race: the read for a
    // following item is issued only after the write has landed in the memory.
    bdeq_ram #(
        .DEPTH_P (DEPTH),
        .WIDTH_P (WORD_W),
        .ADDR_WP (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (accept && we),
        .i_waddr (waddr),
        .i_wdata (i_value),
        .i_re    (accept && re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
            r_ok    <= 1'b0;
            r_rd    <= 1'b0;
        end else begin
            r_valid <= accept;
            if (accept) begin
                r_head  <= n_head;
                r_count <= n_count;
                r_ok    <= ok;
                r_rd    <= re;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_ok         = r_ok;
    assign o_data_out   = r_rd ? rdata : '0;
    assign o_fill_count = FILL_W'(r_count);

    `BDEQ_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    `BDEQ_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, accept, o_valid)
    `BDEQ_ASSERT_SAME(a_fail_zero, i_clk, i_rst_n, o_valid && !o_ok, o_data_out == '0)
    `BDEQ_ASSERT_NEXT(a_idle_holds, i_clk, i_rst_n, !accept, $stable(r_head) && $stable(r_count))

endmodule
